// ----- src/idtm_pkg.sv -----
package idtm_pkg;

   // cell coordinate width of every cell result
   localparam int CELL_BITS = 16;

   // divider geometry: quotient bits before a cell result clamps, dividend and divisor widths
   localparam int QBITS   = 17;
   localparam int NUM_W   = 53;
   localparam int DIV_W   = 51;
   localparam int NLANES  = 4;

   // pipeline geometry
   localparam int FRONT_STG = 5;
   localparam int DIV_STG   = QBITS + 1;
   localparam int NSTG      = FRONT_STG + DIV_STG + 1;

   // divider lanes
   localparam int LANE_LO_X = 0;
   localparam int LANE_LO_Y = 1;
   localparam int LANE_HI_X = 2;
   localparam int LANE_HI_Y = 3;

   typedef enum logic [1:0] {
      FUNC_TO_CELL   = 2'd0,
      FUNC_TO_SCREEN = 2'd1,
      FUNC_TO_NODE   = 2'd2,
      FUNC_BOUNDS    = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      CSR_CELL_WIDTH  = 3'd0,
      CSR_CELL_HEIGHT = 3'd1,
      CSR_CAMERA_X    = 3'd2,
      CSR_CAMERA_Y    = 3'd3,
      CSR_ZOOM        = 3'd4
   } csr_index_type;

   typedef struct packed {
      func_type           func;
      logic signed [23:0] pos_x;
      logic signed [23:0] pos_y;
      logic signed [15:0] cell_in_x;
      logic signed [15:0] cell_in_y;
      logic [22:0]        view_w;
      logic [22:0]        view_h;
   } req_type;

   typedef struct packed {
      logic signed [23:0]          screen_x;
      logic signed [23:0]          screen_y;
      logic signed [CELL_BITS-1:0] cell_lo_x;
      logic signed [CELL_BITS-1:0] cell_lo_y;
      logic signed [CELL_BITS-1:0] cell_hi_x;
      logic signed [CELL_BITS-1:0] cell_hi_y;
      logic                        saturated;
   } rsp_type;

   // effective (zero taken as one) configuration plus derived z*w*h
   typedef struct packed {
      logic [12:0]        cell_w;
      logic [12:0]        cell_h;
      logic [15:0]        zoom;
      logic signed [23:0] cam_x;
      logic signed [23:0] cam_y;
      logic [41:0]        prod;
   } cfg_type;

   typedef struct packed {
      logic             neg;
      logic [NUM_W-1:0] mag;
   } num_type;

   typedef struct packed {
      logic             neg;
      logic             ovf;
      logic [QBITS-1:0] quo;
   } lane_res_type;

   typedef struct packed {
      func_type           func;
      logic signed [23:0] sx;
      logic signed [23:0] sy;
      logic               sat;
   } side_type;

endpackage

// ----- src/isometric_diamond_tile_mapper.sv -----
// an accepted req word passes the front stages, divider lanes and output register in turn
// throughput: one word per cycle unless stalled, from the 17-stage quotient pipe per lane
// a stalled rsp holds only as many words as stages are full; empty stages keep accepting
// reset: synchronous, active high; clears valid bits and loads register defaults
// derived z*w*h product follows a csr write through the zw and prod registers
module isometric_diamond_tile_mapper (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  idtm_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output idtm_pkg::rsp_type  rsp_data,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [23:0]        csr_wdata
);
   import idtm_pkg::*;

   localparam logic signed [19:0] CHI = 20'sd32767;
   localparam logic signed [19:0] CLO = -20'sd32768;

   cfg_type                   cfg;
   logic [NSTG-1:0]           valid_ff;
   logic [NSTG-1:0]           rdy;
   num_type [NLANES-1:0]      num;
   side_type                  side;
   side_type                  side_ff [DIV_STG];
   lane_res_type              lres [NLANES];
   logic [DIV_W-1:0]          dsr;
   rsp_type                   rsp_in, rsp_ff;
   func_type                  out_func_ff;
   logic [CELL_BITS:0]        cl [NLANES];
   logic signed [1:0]         delta [NLANES];

   // register file and derived product
   idtm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // a stage loads when it or any stage downstream has room
   for (genvar i = 0; i < NSTG; i++) begin : g_rdy
      assign rdy[i] = rsp_ready || !(&valid_ff[NSTG-1:i]);
   end

   assign req_ready = rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (rdy[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int i = 1; i < NSTG; i++) begin
            if (rdy[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
      end
   end

   // offsets, products, numerators and screen results: stages 0 to 4
   idtm_front u_front (
      .clock    (clock),
      .req_data (req_data),
      .cfg      (cfg),
      .en       (rdy[FRONT_STG-1:0]),
      .num      (num),
      .side     (side)
   );

   // divisor 2*z*w*h*256; user keeps it constant while words are in flight, not enforced
   assign dsr = DIV_W'({cfg.prod, 9'b0});

   // four divider lanes: x min, y min, x max, y max
   for (genvar k = 0; k < NLANES; k++) begin : g_lane
      idtm_div u_div (
         .clock (clock),
         .en    (rdy[FRONT_STG+DIV_STG-1:FRONT_STG]),
         .num   (num[k]),
         .dsr   (dsr),
         .res   (lres[k])
      );
   end

   // function code and screen result ride alongside the divider
   always_ff @(posedge clock) begin
      if (rdy[FRONT_STG]) begin
         side_ff[0] <= side;
      end
      for (int j = 1; j < DIV_STG; j++) begin
         if (rdy[FRONT_STG+j]) begin
            side_ff[j] <= side_ff[j-1];
         end
      end
   end

   // sign, widen by one for bounds, clamp to the cell range; msb is the clamp flag
   function automatic logic [CELL_BITS:0] clamp_cell(lane_res_type r, logic signed [1:0] d);
      logic signed [19:0] v;
      logic [CELL_BITS:0] o;
      v = r.neg ? -$signed(20'(r.quo)) : $signed(20'(r.quo));
      v = v + 20'(d);
      if (r.ovf) begin
         o = r.neg ? {1'b1, CLO[CELL_BITS-1:0]} : {1'b1, CHI[CELL_BITS-1:0]};
      end else if (v > CHI) begin
         o = {1'b1, CHI[CELL_BITS-1:0]};
      end else if (v < CLO) begin
         o = {1'b1, CLO[CELL_BITS-1:0]};
      end else begin
         o = {1'b0, v[CELL_BITS-1:0]};
      end
      return o;
   endfunction

   always_comb begin
      for (int k = 0; k < NLANES; k++) begin
         if (side_ff[DIV_STG-1].func != FUNC_BOUNDS) begin
            delta[k] = 2'sd0;
         end else if (k == LANE_LO_X || k == LANE_LO_Y) begin
            delta[k] = -2'sd1;
         end else begin
            delta[k] = 2'sd1;
         end
         cl[k] = clamp_cell(lres[k], delta[k]);
      end
   end

   // output word select
   always_comb begin
      rsp_in = '0;
      case (side_ff[DIV_STG-1].func)
         FUNC_TO_CELL, FUNC_TO_NODE: begin
            rsp_in.cell_lo_x = cl[LANE_LO_X][CELL_BITS-1:0];
            rsp_in.cell_lo_y = cl[LANE_LO_Y][CELL_BITS-1:0];
            rsp_in.saturated = cl[LANE_LO_X][CELL_BITS] | cl[LANE_LO_Y][CELL_BITS];
         end
         FUNC_TO_SCREEN: begin
            rsp_in.screen_x  = side_ff[DIV_STG-1].sx;
            rsp_in.screen_y  = side_ff[DIV_STG-1].sy;
            rsp_in.saturated = side_ff[DIV_STG-1].sat;
         end
         FUNC_BOUNDS: begin
            rsp_in.cell_lo_x = cl[LANE_LO_X][CELL_BITS-1:0];
            rsp_in.cell_lo_y = cl[LANE_LO_Y][CELL_BITS-1:0];
            rsp_in.cell_hi_x = cl[LANE_HI_X][CELL_BITS-1:0];
            rsp_in.cell_hi_y = cl[LANE_HI_Y][CELL_BITS-1:0];
            rsp_in.saturated = cl[LANE_LO_X][CELL_BITS] | cl[LANE_LO_Y][CELL_BITS]
                               | cl[LANE_HI_X][CELL_BITS] | cl[LANE_HI_Y][CELL_BITS];
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (rdy[NSTG-1]) begin
         rsp_ff      <= rsp_in;
         out_func_ff <= side_ff[DIV_STG-1].func;
      end
   end

   assign rsp_valid = valid_ff[NSTG-1];
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   a_bounds_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && out_func_ff == FUNC_BOUNDS |->
         rsp_data.cell_lo_x <= rsp_data.cell_hi_x && rsp_data.cell_lo_y <= rsp_data.cell_hi_y)
      else $error("bounds minimum above maximum");

   a_screen_no_cell: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && out_func_ff == FUNC_TO_SCREEN |->
         rsp_data.cell_lo_x == '0 && rsp_data.cell_lo_y == '0 &&
         rsp_data.cell_hi_x == '0 && rsp_data.cell_hi_y == '0)
      else $error("cell fields set on screen result");

   a_cell_no_hi: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (out_func_ff == FUNC_TO_CELL || out_func_ff == FUNC_TO_NODE) |->
         rsp_data.cell_hi_x == '0 && rsp_data.cell_hi_y == '0 &&
         rsp_data.screen_x == '0 && rsp_data.screen_y == '0)
      else $error("unused fields set on cell result");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> &valid_ff)
      else $error("input stalled with an empty stage");

   a_enter: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> valid_ff[0])
      else $error("accepted word lost at entry");
`endif

endmodule

// ----- src/idtm_csr.sv -----
module idtm_csr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [2:0]            csr_index,
   input  logic [23:0]           csr_wdata,
   output idtm_pkg::cfg_type     cfg
);
   import idtm_pkg::*;

   logic [12:0]        width_ff, height_ff;
   logic signed [23:0] cam_x_ff, cam_y_ff;
   logic [15:0]        zoom_ff;
   logic [12:0]        w_eff, h_eff;
   logic [15:0]        z_eff;
   logic [28:0]        zw_in, zw_ff;
   logic [41:0]        prod_in, prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 13'd128;
         height_ff <= 13'd64;
         cam_x_ff  <= '0;
         cam_y_ff  <= '0;
         zoom_ff   <= 16'd256;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CELL_WIDTH:  width_ff  <= csr_wdata[12:0];
            CSR_CELL_HEIGHT: height_ff <= csr_wdata[12:0];
            CSR_CAMERA_X:    cam_x_ff  <= $signed(csr_wdata);
            CSR_CAMERA_Y:    cam_y_ff  <= $signed(csr_wdata);
            CSR_ZOOM:        zoom_ff   <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   assign w_eff = (width_ff == '0) ? 13'd1 : width_ff;
   assign h_eff = (height_ff == '0) ? 13'd1 : height_ff;
   assign z_eff = (zoom_ff == '0) ? 16'd1 : zoom_ff;

   // z*w*h over two registered multiplies, zw_ff then prod_ff, after the csr registers
   assign zw_in   = 29'(z_eff) * 29'(w_eff);
   assign prod_in = 42'(zw_ff) * 42'(h_eff);

   always_ff @(posedge clock) begin
      zw_ff   <= zw_in;
      prod_ff <= prod_in;
   end

   assign cfg.cell_w = w_eff;
   assign cfg.cell_h = h_eff;
   assign cfg.zoom   = z_eff;
   assign cfg.cam_x  = cam_x_ff;
   assign cfg.cam_y  = cam_y_ff;
   assign cfg.prod   = prod_ff;

endmodule

// ----- src/idtm_front.sv -----
module idtm_front (
   input  logic                                    clock,
   input  idtm_pkg::req_type                       req_data,
   input  idtm_pkg::cfg_type                       cfg,
   input  logic [idtm_pkg::FRONT_STG-1:0]          en,
   output idtm_pkg::num_type [idtm_pkg::NLANES-1:0] num,
   output idtm_pkg::side_type                      side
);
   import idtm_pkg::*;

   // stage 0: offsets from camera
   logic signed [24:0] difx, dify;
   logic signed [25:0] dx2_ff, dy2_ff;
   logic [23:0]        ew_in, eh_in, ew_ff, eh_ff;
   logic signed [17:0] tx_in, ty_in, tx_ff, ty_ff;
   func_type           func0_ff;
   // stage 1: products
   logic signed [13:0] ws, hs;
   logic signed [39:0] pxh_ff, pyw_ff;
   logic [36:0]        peh_ff, pew_ff;
   logic signed [31:0] tsx_ff, tsy_ff;
   func_type           func1_ff;
   // stage 2: diamond bases and screen products
   logic signed [41:0] base_in [NLANES];
   logic signed [41:0] base_ff [NLANES];
   logic signed [47:0] msx_ff, msy_ff;
   func_type           func2_ff;
   // stage 3: signed numerators
   logic [49:0]        sub;
   logic signed [51:0] n_ff [NLANES];
   logic signed [47:0] mx_ff, my_ff;
   func_type           func3_ff;
   // stage 4: rounding offsets and screen rounding
   logic [NUM_W-1:0]   p256;
   num_type [NLANES-1:0] num_in, num_ff;
   logic signed [47:0] rx, ry;
   side_type           side_in, side_ff;

   assign difx  = 25'(req_data.pos_x) - 25'(cfg.cam_x);
   assign dify  = 25'(req_data.pos_y) - 25'(cfg.cam_y);
   assign ew_in = (req_data.func == FUNC_BOUNDS) ? {req_data.view_w, 1'b0} : '0;
   assign eh_in = (req_data.func == FUNC_BOUNDS) ? {req_data.view_h, 1'b0} : '0;
   assign tx_in = 18'(req_data.cell_in_x) - 18'(req_data.cell_in_y) + 18'sd1;
   assign ty_in = 18'(req_data.cell_in_x) + 18'(req_data.cell_in_y) + 18'sd1;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         dx2_ff   <= {difx, 1'b0};
         dy2_ff   <= {dify, 1'b0};
         ew_ff    <= ew_in;
         eh_ff    <= eh_in;
         tx_ff    <= tx_in;
         ty_ff    <= ty_in;
         func0_ff <= req_data.func;
      end
   end

   assign ws = $signed({1'b0, cfg.cell_w});
   assign hs = $signed({1'b0, cfg.cell_h});

   always_ff @(posedge clock) begin
      if (en[1]) begin
         pxh_ff   <= 40'(dx2_ff) * 40'(hs);
         pyw_ff   <= 40'(dy2_ff) * 40'(ws);
         peh_ff   <= 37'(ew_ff) * 37'(cfg.cell_h);
         pew_ff   <= 37'(eh_ff) * 37'(cfg.cell_w);
         tsx_ff   <= 32'(tx_ff) * 32'(ws);
         tsy_ff   <= 32'(ty_ff) * 32'(hs);
         func1_ff <= func0_ff;
      end
   end

   // x grows with both view extents, y grows with height and falls with width
   always_comb begin
      base_in[LANE_LO_X] = 42'(pxh_ff) + 42'(pyw_ff);
      base_in[LANE_HI_X] = 42'(pxh_ff) + 42'(pyw_ff) + $signed(42'(peh_ff))
                           + $signed(42'(pew_ff));
      base_in[LANE_LO_Y] = 42'(pyw_ff) - 42'(pxh_ff) - $signed(42'(peh_ff));
      base_in[LANE_HI_Y] = 42'(pyw_ff) - 42'(pxh_ff) + $signed(42'(pew_ff));
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         base_ff  <= base_in;
         msx_ff   <= 48'(tsx_ff) * $signed(48'(cfg.zoom));
         msy_ff   <= 48'(tsy_ff) * $signed(48'(cfg.zoom));
         func2_ff <= func1_ff;
      end
   end

   assign sub = (func2_ff == FUNC_TO_NODE) ? '0 : {cfg.prod, 8'b0};

   always_ff @(posedge clock) begin
      if (en[3]) begin
         for (int k = 0; k < NLANES; k++) begin
            n_ff[k] <= 52'($signed({base_ff[k], 8'b0})) - $signed(52'(sub));
         end
         mx_ff    <= msx_ff + 48'($signed({cfg.cam_x, 1'b0}));
         my_ff    <= msy_ff + 48'($signed({cfg.cam_y, 1'b0}));
         func3_ff <= func2_ff;
      end
   end

   // |n| + p feeds a floor divide by 2p, giving round half away from zero
   assign p256 = NUM_W'({cfg.prod, 8'b0});

   always_comb begin
      for (int k = 0; k < NLANES; k++) begin
         num_in[k].neg = n_ff[k][51];
         num_in[k].mag = n_ff[k][51] ? p256 - NUM_W'(n_ff[k]) : NUM_W'(n_ff[k]) + p256;
      end
   end

   // halve with round half away from zero
   assign rx = (mx_ff >>> 1) + 48'($signed({1'b0, mx_ff[0] & ~mx_ff[47]}));
   assign ry = (my_ff >>> 1) + 48'($signed({1'b0, my_ff[0] & ~my_ff[47]}));

   always_comb begin
      side_in.func = func3_ff;
      side_in.sat  = 1'b0;
      if (rx > 48'sd8388607) begin
         side_in.sx  = 24'sh7fffff;
         side_in.sat = 1'b1;
      end else if (rx < -48'sd8388608) begin
         side_in.sx  = 24'sh800000;
         side_in.sat = 1'b1;
      end else begin
         side_in.sx = rx[23:0];
      end
      if (ry > 48'sd8388607) begin
         side_in.sy  = 24'sh7fffff;
         side_in.sat = 1'b1;
      end else if (ry < -48'sd8388608) begin
         side_in.sy  = 24'sh800000;
         side_in.sat = 1'b1;
      end else begin
         side_in.sy = ry[23:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         num_ff  <= num_in;
         side_ff <= side_in;
      end
   end

   assign num  = num_ff;
   assign side = side_ff;

endmodule

// ----- src/idtm_div.sv -----
module idtm_div (
   input  logic                           clock,
   input  logic [idtm_pkg::DIV_STG-1:0]   en,
   input  idtm_pkg::num_type              num,
   input  logic [idtm_pkg::DIV_W-1:0]     dsr,
   output idtm_pkg::lane_res_type         res
);
   import idtm_pkg::*;

   localparam int EXT_W = DIV_W + QBITS;

   logic [NUM_W-1:0] rem_ff [DIV_STG];
   logic [QBITS-1:0] quo_ff [DIV_STG];
   logic             neg_ff [DIV_STG];
   logic             ovf_ff [DIV_STG];

   // first stage flags quotients too wide for the QBITS-bit quotient register
   always_ff @(posedge clock) begin
      if (en[0]) begin
         rem_ff[0] <= num.mag;
         quo_ff[0] <= '0;
         neg_ff[0] <= num.neg;
         ovf_ff[0] <= EXT_W'(num.mag) >= {dsr, QBITS'(0)};
      end
   end

   // one restoring quotient bit per stage, msb first
   for (genvar j = 1; j < DIV_STG; j++) begin : g_bit
      localparam int B = QBITS - j;
      logic [EXT_W-1:0] shifted;
      logic             ge;

      assign shifted = EXT_W'(dsr) << B;
      assign ge      = EXT_W'(rem_ff[j-1]) >= shifted;

      always_ff @(posedge clock) begin
         if (en[j]) begin
            rem_ff[j] <= ge ? NUM_W'(EXT_W'(rem_ff[j-1]) - shifted) : rem_ff[j-1];
            quo_ff[j] <= quo_ff[j-1] | (QBITS'(ge) << B);
            neg_ff[j] <= neg_ff[j-1];
            ovf_ff[j] <= ovf_ff[j-1];
         end
      end
   end

   assign res.neg = neg_ff[DIV_STG-1];
   assign res.ovf = ovf_ff[DIV_STG-1];
   assign res.quo = quo_ff[DIV_STG-1];

endmodule

// ----- verif/tb_isometric_diamond_tile_mapper.sv -----
`timescale 1ns / 1ps

module tb_isometric_diamond_tile_mapper;
   import idtm_pkg::*;

   // scoreboard: keeps its own copy of the camera and tile registers, predicts the
   // rsp word of every accepted req word and checks rsp words in order
   class tile_map_scoreboard;
      rsp_type    mapped_queue[$];
      longint     cell_w, cell_h, cam_x, cam_y, zoom;
      int         mismatch_count;

      function void load_defaults();
         cell_w = 128;
         cell_h = 64;
         cam_x  = 0;
         cam_y  = 0;
         zoom   = 256;
      endfunction

      function void set_reg(csr_index_type idx, logic [23:0] value);
         case (idx)
            CSR_CELL_WIDTH:  cell_w = value[12:0];
            CSR_CELL_HEIGHT: cell_h = value[12:0];
            CSR_CAMERA_X:    cam_x  = longint'($signed(value));
            CSR_CAMERA_Y:    cam_y  = longint'($signed(value));
            CSR_ZOOM:        zoom   = value[15:0];
            default: ;
         endcase
      endfunction

      function longint nonzero(longint v);
         return (v != 0) ? v : 1;
      endfunction

      // n / d rounded half away from zero, d positive
      function longint round_div(longint n, longint d);
         if (n >= 0)
            return (2 * n + d) / (2 * d);
         return -((-2 * n + d) / (2 * d));
      endfunction

      function longint clamp(longint v, longint lo, longint hi, inout bit sat);
         if (v < lo) begin
            sat = 1;
            return lo;
         end
         if (v > hi) begin
            sat = 1;
            return hi;
         end
         return v;
      endfunction

      // one axis of the inverse diamond map, offsets doubled and in Q.8 units
      function longint grid_axis(longint dx2, longint dy2, bit node, bit yaxis);
         longint w, h, prod, base, n;
         w    = nonzero(cell_w);
         h    = nonzero(cell_h);
         prod = nonzero(zoom) * w * h * 256;
         base = yaxis ? (dy2 * w - dx2 * h) : (dx2 * h + dy2 * w);
         n    = 256 * base - (node ? 0 : prod);
         return round_div(n, 2 * prod);
      endfunction

      // diamond centre to screen, halved and rounded once
      function longint screen_axis(longint t, longint size, longint cam);
         longint m, mag, q;
         m   = t * nonzero(size) * nonzero(zoom) + cam * 2;
         mag = (m < 0) ? -m : m;
         q   = (mag + 1) >>> 1;
         return (m < 0) ? -q : q;
      endfunction

      function rsp_type map_word(req_type r);
         rsp_type res;
         longint  dx2, dy2, gx, gy, mnx, mny, mxx, mxy;
         longint  clo, chi, slo, shi;
         bit      sat;
         clo = -32768;
         chi = 32767;
         slo = -(longint'(1) << 23);
         shi = (longint'(1) << 23) - 1;
         sat = 0;
         res = '0;
         dx2 = 2 * (longint'(r.pos_x) - cam_x);
         dy2 = 2 * (longint'(r.pos_y) - cam_y);
         case (r.func)
            FUNC_TO_CELL, FUNC_TO_NODE: begin
               res.cell_lo_x = 16'(clamp(grid_axis(dx2, dy2, r.func == FUNC_TO_NODE, 0),
                                         clo, chi, sat));
               res.cell_lo_y = 16'(clamp(grid_axis(dx2, dy2, r.func == FUNC_TO_NODE, 1),
                                         clo, chi, sat));
            end
            FUNC_TO_SCREEN: begin
               res.screen_x = 24'(clamp(screen_axis(longint'(r.cell_in_x)
                                                    - longint'(r.cell_in_y) + 1,
                                                    cell_w, cam_x), slo, shi, sat));
               res.screen_y = 24'(clamp(screen_axis(longint'(r.cell_in_x)
                                                    + longint'(r.cell_in_y) + 1,
                                                    cell_h, cam_y), slo, shi, sat));
            end
            default: begin
               for (int a = 0; a < 3; a++) begin
                  for (int b = 0; b < 3; b++) begin
                     gx = grid_axis(dx2 + a * longint'(r.view_w),
                                    dy2 + b * longint'(r.view_h), 0, 0);
                     gy = grid_axis(dx2 + a * longint'(r.view_w),
                                    dy2 + b * longint'(r.view_h), 0, 1);
                     if ((a == 0 && b == 0) || gx < mnx) mnx = gx;
                     if ((a == 0 && b == 0) || gy < mny) mny = gy;
                     if ((a == 0 && b == 0) || gx > mxx) mxx = gx;
                     if ((a == 0 && b == 0) || gy > mxy) mxy = gy;
                  end
               end
               res.cell_lo_x = 16'(clamp(mnx - 1, clo, chi, sat));
               res.cell_lo_y = 16'(clamp(mny - 1, clo, chi, sat));
               res.cell_hi_x = 16'(clamp(mxx + 1, clo, chi, sat));
               res.cell_hi_y = 16'(clamp(mxy + 1, clo, chi, sat));
            end
         endcase
         res.saturated = sat;
         return res;
      endfunction

      function void note_req(req_type r);
         mapped_queue.insert(mapped_queue.size(), map_word(r));
      endfunction

      function void report(string what);
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("mismatch: %s", what);
      endfunction

      function void check_rsp(rsp_type got);
         rsp_type want;
         if (mapped_queue.size() == 0) begin
            report($sformatf("rsp word with nothing pending: %p", got));
            return;
         end
         want = mapped_queue.pop_front();
         if (got.screen_x !== want.screen_x || got.screen_y !== want.screen_y ||
             got.cell_lo_x !== want.cell_lo_x || got.cell_lo_y !== want.cell_lo_y ||
             got.cell_hi_x !== want.cell_hi_x || got.cell_hi_y !== want.cell_hi_y ||
             got.saturated !== want.saturated)
            report($sformatf("expected %p actual %p", want, got));
      endfunction
   endclass

   localparam int CYCLE_LIMIT = 1000000;

   logic          clock = 0;
   logic          reset = 1;
   logic          req_valid = 0;
   logic          req_ready;
   req_type       req_data = '0;
   logic          rsp_valid;
   logic          rsp_ready = 0;
   rsp_type       rsp_data;
   logic          csr_we = 0;
   logic [2:0]    csr_index = '0;
   logic [23:0]   csr_wdata = '0;

   tile_map_scoreboard tracker = new();
   int  cycle_count = 0;
   bit  no_idle = 0;     // last stretch runs at full rate on both sides
   int  rsp_hold = 0;

   isometric_diamond_tile_mapper uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** isometric_diamond_tile_mapper: FAILED **");
         $finish;
      end
   end

   // rsp words are checked as they are taken
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         tracker.check_rsp(rsp_data);
   end

   // receiver stalls in bursts, rsp_ready held low while rsp_hold counts down
   always @(negedge clock) begin
      if (no_idle) begin
         rsp_ready <= 1;
      end else if (rsp_hold > 0) begin
         rsp_hold  <= rsp_hold - 1;
         rsp_ready <= (rsp_hold == 1);
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_hold  <= $urandom_range(1, 12);
         rsp_ready <= 0;
      end else begin
         rsp_ready <= 1;
      end
   end

   // one csr write per falling edge, scoreboard follows along
   task automatic write_reg(csr_index_type idx, logic [23:0] value);
      @(negedge clock);
      csr_we    = 1;
      csr_index = idx;
      csr_wdata = value;
      tracker.set_reg(idx, value);
   endtask

   // full register set, then let the derived product settle
   task automatic set_view(int w, int h, int cx, int cy, int z);
      write_reg(CSR_CELL_WIDTH, 24'(w));
      write_reg(CSR_CELL_HEIGHT, 24'(h));
      write_reg(CSR_CAMERA_X, 24'(cx));
      write_reg(CSR_CAMERA_Y, 24'(cy));
      write_reg(CSR_ZOOM, 24'(z));
      @(negedge clock);
      csr_we = 0;
      repeat (4) @(posedge clock);
   endtask

   // offer one req word and hold it until it is taken
   task automatic send_word(req_type r);
      int gap;
      @(negedge clock);
      if (!no_idle && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 12);
         req_valid = 0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1;
      req_data  = r;
      do @(posedge clock); while (!req_ready);
      tracker.note_req(r);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid = 0;
      while (tracker.mapped_queue.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   function automatic req_type make_word(func_type f, int px, int py, int cx, int cy,
                                         int vw, int vh);
      req_type r;
      r.func      = f;
      r.pos_x     = 24'(px);
      r.pos_y     = 24'(py);
      r.cell_in_x = 16'(cx);
      r.cell_in_y = 16'(cy);
      r.view_w    = 23'(vw);
      r.view_h    = 23'(vh);
      return r;
   endfunction

   // mostly near the camera so results stay in range, some full-range noise
   function automatic int rand_pos(longint cam);
      case ($urandom_range(0, 3))
         0:       return $urandom();
         1:       return int'(cam) + $signed($urandom_range(0, 1 << 21)) - (1 << 20);
         default: return int'(cam) + $signed($urandom_range(0, 1 << 17)) - (1 << 16);
      endcase
   endfunction

   function automatic req_type rand_word();
      req_type r;
      r.func      = func_type'($urandom_range(0, 3));
      r.pos_x     = 24'(rand_pos(tracker.cam_x));
      r.pos_y     = 24'(rand_pos(tracker.cam_y));
      r.cell_in_x = 16'($urandom_range(0, 1) ? $urandom()
                                             : $signed($urandom_range(0, 200)) - 100);
      r.cell_in_y = 16'($urandom_range(0, 1) ? $urandom()
                                             : $signed($urandom_range(0, 200)) - 100);
      r.view_w    = 23'($urandom_range(0, 2) == 0 ? $urandom() : $urandom_range(0, 1 << 18));
      r.view_h    = 23'($urandom_range(0, 2) == 0 ? $urandom() : $urandom_range(0, 1 << 18));
      return r;
   endfunction

   task automatic directed_set();
      // origin, rounding on exact half cells both ways, signed extremes
      send_word(make_word(FUNC_TO_CELL, 0, 0, 0, 0, 0, 0));
      send_word(make_word(FUNC_TO_CELL, 128 * 256, 0, 0, 0, 0, 0));
      send_word(make_word(FUNC_TO_CELL, -128 * 256, 0, 0, 0, 0, 0));
      send_word(make_word(FUNC_TO_CELL, 8388607, 8388607, 0, 0, 0, 0));
      send_word(make_word(FUNC_TO_CELL, -8388608, -8388608, 0, 0, 0, 0));
      send_word(make_word(FUNC_TO_CELL, 8388607, -8388608, 0, 0, 0, 0));
      send_word(make_word(FUNC_TO_NODE, 0, 0, 0, 0, 0, 0));
      send_word(make_word(FUNC_TO_NODE, 64 * 256, 32 * 256, 0, 0, 0, 0));
      send_word(make_word(FUNC_TO_NODE, -8388608, 8388607, 0, 0, 0, 0));
      send_word(make_word(FUNC_TO_SCREEN, 0, 0, 0, 0, 0, 0));
      send_word(make_word(FUNC_TO_SCREEN, 0, 0, 32767, 32767, 0, 0));
      send_word(make_word(FUNC_TO_SCREEN, 0, 0, -32768, -32768, 0, 0));
      send_word(make_word(FUNC_TO_SCREEN, 0, 0, 32767, -32768, 0, 0));
      send_word(make_word(FUNC_TO_SCREEN, 0, 0, -1, 0, 0, 0));
      send_word(make_word(FUNC_BOUNDS, 0, 0, 0, 0, 0, 0));
      send_word(make_word(FUNC_BOUNDS, 0, 0, 0, 0, 640 * 256, 480 * 256));
      send_word(make_word(FUNC_BOUNDS, -8388608, -8388608, 0, 0, 8388607, 8388607));
      send_word(make_word(FUNC_BOUNDS, 8388607, 8388607, 0, 0, 8388607, 0));
      send_word(make_word(FUNC_BOUNDS, 1000, -1000, 0, 0, 1, 1));
   endtask

   task automatic random_run(int count);
      repeat (count) send_word(rand_word());
   endtask

   initial begin
      tracker.load_defaults();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // reset values
      directed_set();
      random_run(100);
      drain();

      // smallest tile, unit zoom below one, camera at the positive corner
      set_view(2, 1, 24'h7FFFFF, 24'h7FFFFF, 1);
      directed_set();
      random_run(200);
      drain();

      // 4096 tile and largest zoom, camera at the negative corner
      set_view(4096, 4096, 24'h800000, 24'h800000, 16'hFFFF);
      directed_set();
      random_run(200);
      drain();

      // zero size and zoom fall back to one
      set_view(0, 0, 0, 0, 0);
      directed_set();
      random_run(150);
      drain();

      // assorted random settings, full register width on some
      for (int p = 0; p < 4; p++) begin
         set_view($urandom_range(2, 300), $urandom_range(1, 200),
                  $urandom(), $urandom(), $urandom_range(32, 2048));
         random_run(180);
         drain();
      end
      set_view($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
      random_run(150);
      drain();

      // full rate on both sides
      set_view(64, 32, 24'h001000, 24'hFFF000, 512);
      no_idle = 1;
      random_run(250);
      drain();

      if (tracker.mismatch_count == 0)
         $display("** isometric_diamond_tile_mapper: PASSED **");
      else
         $display("** isometric_diamond_tile_mapper: FAILED **");
      $finish;
   end

endmodule
